[rtl/equirectangular_point_projection_assert.svh]
// Assertion macros shared by the projection RTL.
// Both macros assume a clock named clk and a synchronous reset named rst.
`ifndef EQUIRECTANGULAR_POINT_PROJECTION_ASSERT_SVH
`define EQUIRECTANGULAR_POINT_PROJECTION_ASSERT_SVH

`ifndef SYNTHESIS
`define EPP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define EPP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define EPP_ASSERT_ALWAYS(label, cond)
`define EPP_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

[rtl/epp_pkg.sv]
package epp_pkg;

  // Pipeline depths, normalization top bit and CORDIC datapath width
  localparam int SqrtSteps   = 32;
  localparam int CordicSteps = 28;
  localparam int NormSteps   = 6;
  localparam int NormTopBit  = 46;
  localparam int CordicW     = 51;

  // Angles in signed Q4.28
  localparam logic signed [31:0] Q28Pi         = 32'sd843314857;
  localparam logic signed [31:0] Q28HalfPi     = 32'sd421657428;
  localparam logic signed [31:0] Q28TwoPi      = 32'sd1686629713;
  localparam logic signed [31:0] Q28PoleMargin = 32'sd26844;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_AXIS_MODE = 3'd0,
    CFG_COL_SCALE = 3'd1,
    CFG_ROW_SCALE = 3'd2,
    CFG_LOW_ELEV  = 3'd3,
    CFG_LAST_COL  = 3'd4,
    CFG_LAST_ROW  = 3'd5
  } cfg_reg_t;

  // Axis remap modes
  typedef enum logic [1:0] {
    AXIS_NATIVE = 2'd0,
    AXIS_ZXY    = 2'd1,
    AXIS_XZY    = 2'd2
  } axis_mode_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [32:0] dist_res;
    logic        point_valid;
  } result_t;

  // Arctangent of 2^-i in Q4.28
  function automatic logic signed [31:0] atan_entry(input int i);
    logic signed [31:0] v;
    case (i)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      24: v = 32'sd16;
      25: v = 32'sd8;
      26: v = 32'sd4;
      27: v = 32'sd2;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/equirectangular_point_projection.sv]
// Equirectangular projection of 3D points onto a panorama image. One point is
// taken every clock cycle (busy stays low) and its result appears on res with
// done high; the receiver cannot stall, so each result is shown for one cycle
// only. Most of the latency comes from the two 32-stage square root pipelines
// and the 35-stage CORDIC pipelines behind them. Points with a zero remapped
// coordinate still take the full latency and come out with point_valid low and
// all other fields zero. Configuration writes are always ready and should be
// made while no point is in flight.
module equirectangular_point_projection
  import epp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  point_t      pt,
  output logic        done,
  output result_t     res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

`include "equirectangular_point_projection_assert.svh"

  localparam int FrontLen = 2 + SqrtSteps;
  localparam int BackLen  = NormSteps + CordicSteps;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic signed [32:0] a;
    logic signed [32:0] b;
    logic signed [32:0] c;
  } front_t;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [31:0] range;
  } back_t;

  // Configuration registers
  logic [1:0]         axis_mode;
  logic [31:0]        col_scale;
  logic [31:0]        row_scale;
  logic signed [29:0] low_elevation;
  logic [15:0]        last_col;
  logic [15:0]        last_row;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode     <= 2'd0;
      col_scale     <= 32'd37549817;
      row_scale     <= 32'd37549817;
      low_elevation <= -30'sd421657428;
      last_col      <= 16'd3599;
      last_row      <= 16'd1799;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_AXIS_MODE: axis_mode     <= cfg_data[1:0];
        CFG_COL_SCALE: col_scale     <= cfg_data;
        CFG_ROW_SCALE: row_scale     <= cfg_data;
        CFG_LOW_ELEV:  low_elevation <= cfg_data[29:0];
        CFG_LAST_COL:  last_col      <= cfg_data[15:0];
        CFG_LAST_ROW:  last_row      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Remap axes of the incoming word
  logic signed [32:0] sx, sy, sz, ra, rb, rc;
  logic [31:0]        ma_next, mb_next, mc_next;

  always_comb begin
    sx = 33'(pt.px);
    sy = 33'(pt.py);
    sz = 33'(pt.pz);
    case (axis_mode_t'(axis_mode))
      AXIS_ZXY: begin
        ra = sz; rb = -sx; rc = sy;
      end
      AXIS_XZY: begin
        ra = sx; rb = -sz; rc = sy;
      end
      default: begin
        ra = sx; rb = sy; rc = sz;
      end
    endcase
    ma_next = (ra < 0) ? 32'(-ra) : 32'(ra);
    mb_next = (rb < 0) ? 32'(-rb) : 32'(rb);
    mc_next = (rc < 0) ? 32'(-rc) : 32'(rc);
  end

  front_t      front [FrontLen+1];
  logic [31:0] ma, mb, mc;

  always_ff @(posedge clk) begin
    ma <= ma_next;
    mb <= mb_next;
    mc <= mc_next;
    if (rst) begin
      for (int k = 0; k <= FrontLen; k++) front[k] <= '0;
    end else begin
      front[0].valid <= start && !busy;
      front[0].zero  <= (ra == 0) || (rb == 0) || (rc == 0);
      front[0].a     <= ra;
      front[0].b     <= rb;
      front[0].c     <= rc;
      for (int k = 0; k < FrontLen; k++) front[k+1] <= front[k];
    end
  end

  // Square, then sum
  logic [63:0] sq_a, sq_b, sq_c, sxy, s3;

  always_ff @(posedge clk) begin
    sq_a <= 64'(ma) * 64'(ma);
    sq_b <= 64'(mb) * 64'(mb);
    sq_c <= 64'(mc) * 64'(mc);
    sxy  <= sq_a + sq_b;
    s3   <= sq_a + sq_b + sq_c;
  end

  logic [31:0] range_root, horiz;

  epp_isqrt u_sqrt_range (
    .clk  (clk),
    .rad  (s3),
    .root (range_root)
  );

  epp_isqrt u_sqrt_horiz (
    .clk  (clk),
    .rad  (sxy),
    .root (horiz)
  );

  // Elevation and azimuth angles
  logic signed [31:0] elev, az_raw;

  epp_cordic u_cordic_elev (
    .clk   (clk),
    .x_in  ({2'b00, horiz}),
    .y_in  (34'(front[FrontLen].c)),
    .angle (elev)
  );

  epp_cordic u_cordic_az (
    .clk   (clk),
    .x_in  (34'(front[FrontLen].a)),
    .y_in  (34'(front[FrontLen].b)),
    .angle (az_raw)
  );

  back_t back [BackLen+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= BackLen; k++) back[k] <= '0;
    end else begin
      back[0].valid <= front[FrontLen].valid;
      back[0].zero  <= front[FrontLen].zero;
      back[0].range <= range_root;
      for (int k = 0; k < BackLen; k++) back[k+1] <= back[k];
    end
  end

  // Wrap azimuth, apply pole rule, form angle offsets
  logic signed [31:0] elev_mag, az_wrap, az_sel;
  logic signed [32:0] d_next;
  logic               pole;

  always_comb begin
    elev_mag = (elev < 0) ? -elev : elev;
    pole     = (Q28HalfPi - elev_mag) < Q28PoleMargin;
    az_wrap  = az_raw;
    if (az_wrap < 0) az_wrap = az_wrap + Q28TwoPi;
    if (az_wrap >= Q28TwoPi) az_wrap = az_wrap - Q28TwoPi;
    az_sel   = pole ? 32'sd0 : az_wrap;
    d_next   = 33'(elev) - 33'(low_elevation);
  end

  back_t       e1_tail, e2_tail;
  logic [30:0] col_ang;
  logic        d_neg, e2_neg;
  logic [31:0] d_mag;

  always_ff @(posedge clk) begin
    col_ang <= 31'(Q28TwoPi - az_sel);
    d_neg   <= d_next < 0;
    d_mag   <= (d_next < 0) ? 32'(-d_next) : 32'(d_next);
    if (rst) e1_tail <= '0;
    else     e1_tail <= back[BackLen];
  end

  // Scale angles to pixels
  logic [63:0] col_prod, row_prod;

  always_ff @(posedge clk) begin
    col_prod <= 64'(col_scale) * 64'(col_ang);
    row_prod <= 64'(row_scale) * 64'(d_mag);
    e2_neg   <= d_neg;
    if (rst) e2_tail <= '0;
    else     e2_tail <= e1_tail;
  end

  // Clamp to the image and drive the result word
  logic [19:0]        colv, rowt;
  logic signed [21:0] j;
  logic [15:0]        col_next, row_next;

  always_comb begin
    colv     = col_prod[63:44];
    rowt     = row_prod[63:44];
    col_next = (colv > 20'(last_col)) ? last_col : colv[15:0];
    j        = e2_neg ? 22'(last_row) + 22'(rowt) : 22'(last_row) - 22'(rowt);
    if (j < 0)                row_next = 16'd0;
    else if (j > 22'(last_row)) row_next = last_row;
    else                      row_next = j[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e2_tail.valid;
    end
    if (e2_tail.zero) begin
      res <= '0;
    end else begin
      res.col         <= col_next;
      res.row         <= row_next;
      res.dist_res    <= 33'(e2_tail.range);
      res.point_valid <= 1'b1;
    end
  end

  `EPP_ASSERT_IMPLY(a_col_clamped, done, res.col <= last_col)
  `EPP_ASSERT_IMPLY(a_row_clamped, done, res.row <= last_row)
  `EPP_ASSERT_IMPLY(a_reject_zero, done && !res.point_valid, res.col == 16'd0 && res.row == 16'd0 && res.dist_res == 33'd0)
  `EPP_ASSERT_IMPLY(a_range_nonzero, done && res.point_valid, res.dist_res != 33'd0)

endmodule

[rtl/epp_isqrt.sv]
// Floor square root of a 64-bit value, one result bit per stage.
module epp_isqrt
  import epp_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] v [SqrtSteps+1];
  logic [63:0] r [SqrtSteps+1];

  assign v[0] = rad;
  assign r[0] = '0;

  // Try one root bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = r[k] + Bit;
    always_ff @(posedge clk) begin
      if (v[k] >= trial) begin
        v[k+1] <= v[k] - trial;
        r[k+1] <= (r[k] >> 1) + Bit;
      end else begin
        v[k+1] <= v[k];
        r[k+1] <= r[k] >> 1;
      end
    end
  end

  assign root = r[SqrtSteps][31:0];

endmodule

[rtl/epp_cordic.sv]
// Vectoring CORDIC arctangent: pre-rotate, normalize, then one micro-rotation per stage.
module epp_cordic
  import epp_pkg::*;
(
  input  logic               clk,
  input  logic signed [33:0] x_in,
  input  logic signed [33:0] y_in,
  output logic signed [31:0] angle
);

  localparam int Stages = NormSteps + CordicSteps;

  logic signed [CordicW-1:0] x   [Stages+1];
  logic signed [CordicW-1:0] y   [Stages+1];
  logic signed [31:0]        acc [Stages+1];
  logic [47:0]               m   [NormSteps+1];

  logic signed [33:0] xr;
  logic signed [33:0] yr;
  logic [33:0]        ya;

  // Pre-rotate a left-half vector by pi
  always_comb begin
    xr = (x_in < 0) ? -x_in : x_in;
    yr = (x_in < 0) ? -y_in : y_in;
    ya = (yr < 0) ? 34'(-yr) : 34'(yr);
  end

  always_ff @(posedge clk) begin
    x[0]   <= CordicW'(xr);
    y[0]   <= CordicW'(yr);
    acc[0] <= (x_in < 0) ? Q28Pi : 32'sd0;
    m[0]   <= 48'((34'(xr) > ya) ? 34'(xr) : ya);
  end

  // Double both operands until the larger magnitude reaches the top bit
  for (genvar k = 0; k < NormSteps; k++) begin : g_norm
    localparam int Sh = 1 << (NormSteps - 1 - k);
    logic fits;
    assign fits = m[k] < (48'd1 << (NormTopBit + 1 - Sh));
    always_ff @(posedge clk) begin
      acc[k+1] <= acc[k];
      if (fits) begin
        m[k+1] <= m[k] << Sh;
        x[k+1] <= x[k] <<< Sh;
        y[k+1] <= y[k] <<< Sh;
      end else begin
        m[k+1] <= m[k];
        x[k+1] <= x[k];
        y[k+1] <= y[k];
      end
    end
  end

  // Rotate toward the x axis, one table angle per stage
  for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
    localparam int S = NormSteps + i;
    localparam logic signed [31:0] Step = atan_entry(i);
    always_ff @(posedge clk) begin
      if (y[S] >= 0) begin
        x[S+1]   <= x[S] + (y[S] >>> i);
        y[S+1]   <= y[S] - (x[S] >>> i);
        acc[S+1] <= acc[S] + Step;
      end else begin
        x[S+1]   <= x[S] - (y[S] >>> i);
        y[S+1]   <= y[S] + (x[S] >>> i);
        acc[S+1] <= acc[S] - Step;
      end
    end
  end

  assign angle = acc[Stages];

endmodule
